// File: hw/rtl/tssg_pkg.sv
// Shared types and constants of the triangle scanline span generator.
// No dependencies.
package tssg_pkg;

   localparam int RowBits         = 6;
   localparam int FracBits        = 16;
   localparam int DefRowCount     = 64;
   localparam int DefCoordBits    = 10;

   // division jobs, in the order the controller runs them
   typedef enum logic [2:0] {
      OP_MX = 3'd0,   // split point on the long edge
      OP_B1 = 3'd1,   // flat-bottom short edge slope
      OP_B2 = 3'd2,   // flat-bottom long edge slope
      OP_T1 = 3'd3,   // flat-top short edge slope
      OP_T2 = 3'd4    // flat-top long edge slope
   } op_type;

   typedef struct packed {
      logic   load;       // capture and sort the request
      logic   prod;       // form split product, set up accumulators
      logic   div_start;  // load divider for op
      logic   div_store;  // divider done, keep result for op
      logic   emit_bot;   // send one flat-bottom span
      logic   emit_top;   // send one flat-top span
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic zero_height;
      logic flat_top;     // y0 == y1
      logic flat_bot;     // y1 == y2
      logic bot_end;      // bottom row counter at y1
      logic top_end;      // top row counter at y1 + 1
   } stat_type;

endpackage

// File: hw/rtl/triangle_scanline_span_generator.sv
// Setup runs the five serial divisions, one quotient bit a cycle; spans then come one per cycle.
// A new triangle is taken only after the controller has issued every span (up to ROW_COUNT) of the last one.
// Zero-height triangles return to idle straight from the product step with no span.
// Reset (synchronous, active high) returns to idle and drops the span strobe.
// The receiver cannot stall; each span is on rsp_* for exactly one cycle.
module triangle_scanline_span_generator #(
   parameter int ROW_COUNT  = tssg_pkg::DefRowCount,
   parameter int COORD_BITS = tssg_pkg::DefCoordBits
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel: taken when start is high and busy is low
   input  logic                         start,
   output logic                         busy,
   input  logic [COORD_BITS-1:0]        req_vert_a_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_a_y,
   input  logic [COORD_BITS-1:0]        req_vert_b_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_b_y,
   input  logic [COORD_BITS-1:0]        req_vert_c_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_c_y,
   input  logic [31:0]                  req_fill_color,
   // span channel: one-cycle strobe
   output logic                         rsp_valid,
   output logic [tssg_pkg::RowBits-1:0] rsp_span_row,
   output logic [COORD_BITS-1:0]        rsp_span_start,
   output logic [COORD_BITS-1:0]        rsp_span_end,
   output logic [31:0]                  rsp_span_color,
   output logic                         rsp_span_last
);
   tssg_pkg::cmd_type  cmd;
   tssg_pkg::stat_type stat;

   // controller: walks sort -> split point -> four slopes -> bottom spans -> top spans; empty phases are skipped
   tssg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // datapath: sorted vertices, shared divider, 16-fraction-bit edge walkers
   tssg_datapath #(
      .ROW_COUNT  (ROW_COUNT),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_vert_a_x   (req_vert_a_x),
      .req_vert_a_y   (req_vert_a_y),
      .req_vert_b_x   (req_vert_b_x),
      .req_vert_b_y   (req_vert_b_y),
      .req_vert_c_x   (req_vert_c_x),
      .req_vert_c_y   (req_vert_c_y),
      .req_fill_color (req_fill_color),
      .rsp_valid      (rsp_valid),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_span_color (rsp_span_color),
      .rsp_span_last  (rsp_span_last)
   );
endmodule

// File: hw/rtl/tssg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by tssg_datapath.
module tssg_div #(
   parameter int DW = 27,
   parameter int VW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic          rem_nz
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[VW]) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = (rem_ff != '0);
endmodule

// File: hw/rtl/tssg_datapath.sv
// Datapath: vertex sort, split product, split-point and slope division, edge accumulators, span register.
// Depends on tssg_pkg and tssg_div.
module tssg_datapath #(
   parameter int ROW_COUNT  = tssg_pkg::DefRowCount,
   parameter int COORD_BITS = tssg_pkg::DefCoordBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tssg_pkg::cmd_type            cmd,
   output tssg_pkg::stat_type           stat,
   input  logic [COORD_BITS-1:0]        req_vert_a_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_a_y,
   input  logic [COORD_BITS-1:0]        req_vert_b_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_b_y,
   input  logic [COORD_BITS-1:0]        req_vert_c_x,
   input  logic [tssg_pkg::RowBits-1:0] req_vert_c_y,
   input  logic [31:0]                  req_fill_color,
   output logic                         rsp_valid,
   output logic [tssg_pkg::RowBits-1:0] rsp_span_row,
   output logic [COORD_BITS-1:0]        rsp_span_start,
   output logic [COORD_BITS-1:0]        rsp_span_end,
   output logic [31:0]                  rsp_span_color,
   output logic                         rsp_span_last
);
   localparam int CB = COORD_BITS;
   localparam int RB = tssg_pkg::RowBits;
   localparam int FB = tssg_pkg::FracBits;
   localparam int SW = CB + FB + 2;     // signed slope / accumulator / numerator
   localparam int DW = CB + FB + 1;     // dividend magnitude
   localparam int PW = CB + RB + 2;     // signed split product
   localparam logic [RB-1:0] YMax = RB'(ROW_COUNT - 1);

   logic [CB-1:0] sx [3];
   logic [RB-1:0] sy [3];
   logic [CB-1:0] x0_ff, x1_ff, x2_ff, mx_ff;
   logic [RB-1:0] y0_ff, y1_ff, y2_ff;
   logic [31:0]   color_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [SW-1:0] s1b_ff, s2b_ff, s1t_ff, s2t_ff;
   logic signed [SW-1:0] ab_ff, bb_ff, at_ff, bt_ff;
   logic [RB-1:0] rowb_ff, rowt_ff;
   logic          neg_ff;
   logic signed [SW-1:0] num;
   logic [RB-1:0]        dvs;
   logic [DW-1:0]        mag;
   logic                 div_done;
   logic [DW-1:0]        quo;
   logic                 rnz;
   logic signed [SW-1:0] qe, q_up, q_dn, mx_full;
   logic                 rsp_valid_ff;
   logic [RB-1:0]        row_o_ff;
   logic [CB-1:0]        start_o_ff, end_o_ff;
   logic [31:0]          color_o_ff;
   logic                 last_o_ff;

   // three compare-swaps: (0,2), (0,1), (1,2)
   always_comb begin
      logic [CB-1:0] tx;
      logic [RB-1:0] ty;
      tx = '0;
      ty = '0;
      sx[0] = req_vert_a_x;
      sx[1] = req_vert_b_x;
      sx[2] = req_vert_c_x;
      sy[0] = (req_vert_a_y > YMax) ? YMax : req_vert_a_y;
      sy[1] = (req_vert_b_y > YMax) ? YMax : req_vert_b_y;
      sy[2] = (req_vert_c_y > YMax) ? YMax : req_vert_c_y;
      if (sy[0] > sy[2] || (sy[0] == sy[2] && sx[0] >= sx[2])) begin
         tx = sx[0]; sx[0] = sx[2]; sx[2] = tx;
         ty = sy[0]; sy[0] = sy[2]; sy[2] = ty;
      end
      if (sy[0] > sy[1] || (sy[0] == sy[1] && sx[0] >= sx[1])) begin
         tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
         ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      end
      if (sy[1] > sy[2] || (sy[1] == sy[2] && sx[1] >= sx[2])) begin
         tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
         ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
      end
   end

   // numerator and divisor per job
   always_comb begin
      case (cmd.op)
         tssg_pkg::OP_MX: begin
            num = SW'(prod_ff);
            dvs = y2_ff - y0_ff;
         end
         tssg_pkg::OP_B1: begin
            num = signed'({2'b00, x1_ff, FB'(0)}) - signed'({2'b00, x0_ff, FB'(0)});
            dvs = y1_ff - y0_ff;
         end
         tssg_pkg::OP_B2: begin
            num = signed'({2'b00, mx_ff, FB'(0)}) - signed'({2'b00, x0_ff, FB'(0)});
            dvs = y1_ff - y0_ff;
         end
         tssg_pkg::OP_T1: begin
            num = signed'({2'b00, x2_ff, FB'(0)}) - signed'({2'b00, x1_ff, FB'(0)});
            dvs = y2_ff - y1_ff;
         end
         default: begin
            num = signed'({2'b00, x2_ff, FB'(0)}) - signed'({2'b00, mx_ff, FB'(0)});
            dvs = y2_ff - y1_ff;
         end
      endcase
      mag = num[SW-1] ? DW'(-num) : DW'(num);
   end

   tssg_div #(.DW(DW), .VW(RB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo),
      .rem_nz   (rnz)
   );

   // signed results: truncate, ceiling, floor
   always_comb begin
      qe      = signed'(SW'(quo));
      q_up    = neg_ff ? -qe : qe + SW'(rnz);
      q_dn    = neg_ff ? -(qe + SW'(rnz)) : qe;
      mx_full = signed'(SW'(x0_ff)) + (neg_ff ? -qe : qe);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff    <= sx[0];
         x1_ff    <= sx[1];
         x2_ff    <= sx[2];
         y0_ff    <= sy[0];
         y1_ff    <= sy[1];
         y2_ff    <= sy[2];
         color_ff <= req_fill_color;
      end
      if (cmd.prod) begin
         prod_ff <= (signed'({2'b00, x2_ff}) - signed'({2'b00, x0_ff}))
                    * signed'(PW'({1'b0, y1_ff - y0_ff}));
         ab_ff   <= signed'(SW'({x0_ff, FB'(0)}));
         bb_ff   <= signed'(SW'({x0_ff, FB'(0)}));
         at_ff   <= signed'(SW'({x2_ff, FB'(0)}));
         bt_ff   <= signed'(SW'({x2_ff, FB'(0)}));
         rowb_ff <= y0_ff;
         rowt_ff <= y2_ff;
      end
      if (cmd.div_start)
         neg_ff <= num[SW-1];
      if (cmd.div_store) begin
         case (cmd.op)
            tssg_pkg::OP_MX: mx_ff  <= mx_full[CB-1:0];
            tssg_pkg::OP_B1: s1b_ff <= q_up;
            tssg_pkg::OP_B2: s2b_ff <= q_up;
            tssg_pkg::OP_T1: s1t_ff <= q_dn;
            default:         s2t_ff <= q_dn;
         endcase
      end
      if (cmd.emit_bot) begin
         ab_ff   <= ab_ff + s1b_ff;
         bb_ff   <= bb_ff + s2b_ff;
         rowb_ff <= rowb_ff + 1'b1;
      end
      if (cmd.emit_top) begin
         at_ff   <= at_ff - s1t_ff;
         bt_ff   <= bt_ff - s2t_ff;
         rowt_ff <= rowt_ff - 1'b1;
      end
      // span output register
      if (cmd.emit_bot) begin
         row_o_ff   <= rowb_ff;
         start_o_ff <= ab_ff[CB+FB-1:FB];
         end_o_ff   <= bb_ff[CB+FB-1:FB];
         last_o_ff  <= stat.bot_end && stat.flat_bot;
      end else begin
         row_o_ff   <= rowt_ff;
         start_o_ff <= at_ff[CB+FB-1:FB];
         end_o_ff   <= bt_ff[CB+FB-1:FB];
         last_o_ff  <= stat.top_end;
      end
      color_o_ff <= color_ff;
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.emit_bot || cmd.emit_top;
   end

   assign stat.div_done    = div_done;
   assign stat.zero_height = (y0_ff == y2_ff);
   assign stat.flat_top    = (y0_ff == y1_ff);
   assign stat.flat_bot    = (y1_ff == y2_ff);
   assign stat.bot_end     = (rowb_ff == y1_ff);
   assign stat.top_end     = ({1'b0, rowt_ff} == ({1'b0, y1_ff} + 1'b1));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_row   = row_o_ff;
   assign rsp_span_start = start_o_ff;
   assign rsp_span_end   = end_o_ff;
   assign rsp_span_color = color_o_ff;
   assign rsp_span_last  = last_o_ff;
endmodule

// File: hw/rtl/tssg_ctrl.sv
// Controller: sequences sort, five divisions and the two span phases.
// Depends on tssg_pkg.
module tssg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output tssg_pkg::cmd_type  cmd,
   input  tssg_pkg::stat_type stat
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PROD  = 6'b000010,
      ST_DLOAD = 6'b000100,
      ST_DWAIT = 6'b001000,
      ST_EBOT  = 6'b010000,
      ST_ETOP  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   tssg_pkg::op_type op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            op_in    = tssg_pkg::OP_MX;
            state_in = stat.zero_height ? ST_IDLE : ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_DLOAD;
               case (op_ff)
                  tssg_pkg::OP_MX: op_in = tssg_pkg::OP_B1;
                  tssg_pkg::OP_B1: op_in = tssg_pkg::OP_B2;
                  tssg_pkg::OP_B2: op_in = tssg_pkg::OP_T1;
                  tssg_pkg::OP_T1: op_in = tssg_pkg::OP_T2;
                  default:         state_in = stat.flat_top ? ST_ETOP : ST_EBOT;
               endcase
            end
         end
         ST_EBOT: begin
            cmd.emit_bot = 1'b1;
            if (stat.bot_end)
               state_in = stat.flat_bot ? ST_IDLE : ST_ETOP;
         end
         ST_ETOP: begin
            cmd.emit_top = 1'b1;
            if (stat.top_end)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= tssg_pkg::OP_MX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// File: hw/rtl/tssg_checker.sv
// Port-level checks of the span generator, bound to the top level.
// Depends on triangle_scanline_span_generator.
module tssg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_span_last
);
   // an accepted request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after request");

   // spans only come out of work that was running
   a_span_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("span without work");

   // spans of one triangle are back to back
   a_spans_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_last |=> rsp_valid) else $error("gap in spans");

   // final span leaves the block idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_last |-> !busy) else $error("busy at last span");
endmodule

bind triangle_scanline_span_generator tssg_checker u_tssg_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_span_last (rsp_span_last)
);
